// ===== design/ted_pkg.sv =====
`timescale 1ns / 1ps

package ted_pkg;

  // Parser position inside an escape sequence
  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_ESC      = 4'd1,
    ST_SS3      = 4'd2,
    ST_CSI      = 4'd3,
    ST_MBTN     = 4'd4,
    ST_MX       = 4'd5,
    ST_MY       = 4'd6,
    ST_ONE      = 4'd7,
    ST_ONE_TAIL = 4'd8,
    ST_TWO      = 4'd9,
    ST_TWO_TAIL = 4'd10,
    ST_CSI_TAIL = 4'd11
  } state_t;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_SPECIAL = 2'd1,
    KIND_MOUSE   = 2'd2,
    KIND_QUIT    = 2'd3
  } kind_t;

  localparam logic [7:0] CH_QUIT   = 8'd3;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_SS3    = 8'd79;
  localparam logic [7:0] CH_CSI    = 8'd91;
  localparam logic [7:0] CH_MOUSE  = 8'd77;
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CH_ONE    = 8'd49;
  localparam logic [7:0] CH_TWO    = 8'd50;
  localparam logic [7:0] FKEY_OFS  = 8'd80;
  localparam logic [7:0] MOUSE_OFS = 8'd33;
  localparam logic [7:0] FKEY_GAP  = 8'd53;
  localparam logic [7:0] CSI_FINAL = 8'd64;

  localparam int          FifoDepth = 4;
  localparam int          PtrW      = $clog2(FifoDepth);
  localparam int          CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] key;
    logic [7:0] btn;
    logic [7:0] mx;
    logic [7:0] my;
    logic       last;
  } result_t;

  // Everything one byte does to the parser
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
    state_t     state;
    logic [7:0] code;
    logic [7:0] button;
    logic [7:0] column;
  } step_t;

endpackage

// ===== design/ted_decode.sv =====
`timescale 1ns / 1ps

module ted_decode import ted_pkg::*; (
  input  state_t     state,
  input  logic [7:0] held_code,
  input  logic [7:0] held_button,
  input  logic [7:0] held_column,
  input  logic [7:0] rx_byte,
  output step_t      step
);

  function automatic result_t mk_key(kind_t kind, logic [7:0] key);
    result_t r;
    r      = '0;
    r.kind = kind;
    r.key  = key;
    return r;
  endfunction

  logic [7:0] one_code;
  assign one_code = rx_byte - CH_ONE - ((rx_byte > FKEY_GAP) ? 8'd1 : 8'd0);

  always_comb begin
    step        = '0;
    step.state  = ST_IDLE;
    step.code   = held_code;
    step.button = held_button;
    step.column = held_column;
    case (state)
      ST_ESC: begin
        if (rx_byte == CH_SS3) begin
          step.state = ST_SS3;
        end else if (rx_byte == CH_CSI) begin
          step.state = ST_CSI;
        end else begin
          // lone ESC comes out as a key, then the byte is decoded from idle
          step.res0 = mk_key(KIND_PLAIN, CH_ESC);
          if (rx_byte == CH_QUIT) begin
            step.res1 = mk_key(KIND_QUIT, 8'd0);
            step.n    = 2'd2;
          end else if (rx_byte == CH_ESC) begin
            step.state = ST_ESC;
            step.n     = 2'd1;
          end else begin
            step.res1 = mk_key(KIND_PLAIN, rx_byte);
            step.n    = 2'd2;
          end
        end
      end
      ST_SS3: begin
        step.res0 = mk_key(KIND_SPECIAL, rx_byte - FKEY_OFS);
        step.n    = 2'd1;
      end
      ST_CSI: begin
        if (rx_byte == CH_MOUSE) begin
          step.state = ST_MBTN;
        end else if (rx_byte == CH_ONE) begin
          step.state = ST_ONE;
        end else if (rx_byte == CH_TWO) begin
          step.state = ST_TWO;
        end else if (rx_byte > CSI_FINAL) begin
          step.res0 = mk_key(KIND_SPECIAL, rx_byte);
          step.n    = 2'd1;
        end else begin
          step.code  = rx_byte;
          step.state = ST_CSI_TAIL;
        end
      end
      ST_MBTN: begin
        step.button = rx_byte;
        step.state  = ST_MX;
      end
      ST_MX: begin
        step.column = rx_byte - MOUSE_OFS;
        step.state  = ST_MY;
      end
      ST_MY: begin
        step.res0.kind = KIND_MOUSE;
        step.res0.btn  = held_button;
        step.res0.mx   = held_column;
        step.res0.my   = rx_byte - MOUSE_OFS;
        step.n         = 2'd1;
      end
      ST_ONE: begin
        if (rx_byte == CH_TILDE) begin
          step.res0 = mk_key(KIND_SPECIAL, CH_ONE);
          step.n    = 2'd1;
        end else begin
          step.code  = one_code;
          step.state = ST_ONE_TAIL;
        end
      end
      ST_ONE_TAIL, ST_CSI_TAIL: begin
        step.res0 = mk_key(KIND_SPECIAL, held_code);
        step.n    = 2'd1;
      end
      ST_TWO: begin
        if (rx_byte == CH_TILDE) begin
          step.res0 = mk_key(KIND_SPECIAL, CH_TWO);
          step.n    = 2'd1;
        end else begin
          step.state = ST_TWO_TAIL;
        end
      end
      ST_TWO_TAIL: begin
        step.state = ST_IDLE;
      end
      default: begin
        if (rx_byte == CH_QUIT) begin
          step.res0 = mk_key(KIND_QUIT, 8'd0);
          step.n    = 2'd1;
        end else if (rx_byte == CH_ESC) begin
          step.state = ST_ESC;
        end else begin
          step.res0 = mk_key(KIND_PLAIN, rx_byte);
          step.n    = 2'd1;
        end
      end
    endcase
    step.res0.last = (step.n == 2'd1);
    step.res1.last = 1'b1;
  end

endmodule

// ===== design/terminal_escape_input_decoder_core.sv =====
`timescale 1ns / 1ps
// Channel | Ports                                   | Beat
// in      | in_valid, in_ready, in_rx_byte          | one terminal byte
// out     | out_valid, out_ready, out_event_kind,   | one event
//         | out_key_code, out_mouse_*, out_last     |
// A byte is decoded in the cycle it is accepted; its events reach the output
// queue at that edge and are offered from the next cycle, one per cycle while out_ready is high.
// One byte per cycle is taken while the 4-entry event queue has two free slots;
// an ESC followed by an ordinary byte yields two events, but the ESC itself gave
// none, so with out_ready high input is never held back.
// rst_n (synchronous) returns the parser to idle and empties the queue.
// out_ready low only stalls input once the queue has fewer than two free slots.

module terminal_escape_input_decoder_core import ted_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_key_code,
  output logic [7:0] out_mouse_button,
  output logic [7:0] out_mouse_x,
  output logic [7:0] out_mouse_y,
  output logic       out_last
);

  state_t          state_r;
  logic [7:0]      held_code_r, held_button_r, held_column_r;
  step_t           step;
  result_t         fifo_r [FifoDepth];
  logic [PtrW-1:0] head_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [PtrW-1:0] tail0, tail1;
  logic            in_fire, out_fire;
  logic [CntW-1:0] push_n;
  result_t         head_res;

  ted_decode u_dec (
    .state       (state_r),
    .held_code   (held_code_r),
    .held_button (held_button_r),
    .held_column (held_column_r),
    .rx_byte     (in_rx_byte),
    .step        (step)
  );

  assign in_ready = (count_r <= CntW'(FifoDepth - 2));
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign push_n    = in_fire ? CntW'(step.n) : '0;
  assign tail0     = head_r + count_r[PtrW-1:0];
  assign tail1     = tail0 + PtrW'(1);
  assign count_nxt = count_r + push_n - (out_fire ? CntW'(1) : CntW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      held_code_r   <= '0;
      held_button_r <= '0;
      held_column_r <= '0;
      head_r        <= '0;
      count_r       <= '0;
    end else begin
      if (in_fire) begin
        state_r       <= step.state;
        held_code_r   <= step.code;
        held_button_r <= step.button;
        held_column_r <= step.column;
      end
      if (out_fire) begin
        head_r <= head_r + PtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step.n != 2'd0) begin
      fifo_r[tail0] <= step.res0;
    end
    if (in_fire && step.n == 2'd2) begin
      fifo_r[tail1] <= step.res1;
    end
  end

  assign head_res         = fifo_r[head_r];
  assign out_event_kind   = head_res.kind;
  assign out_key_code     = head_res.key;
  assign out_mouse_button = head_res.btn;
  assign out_mouse_x      = head_res.mx;
  assign out_mouse_y      = head_res.my;
  assign out_last         = head_res.last;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(FifoDepth))
    else $error("event queue overfilled");

  a_pair_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step.n == 2'd2) |-> (!step.res0.last && step.res1.last))
    else $error("two-event byte marked wrong");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && !in_fire) |=> (count_r == '0))
    else $error("event appeared without an input beat");

  a_quit_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r == ST_IDLE && in_rx_byte == CH_QUIT) |=>
      (state_r == ST_IDLE && count_r != '0))
    else $error("quit byte mishandled");

endmodule

// ===== tb/tb_terminal_escape_input_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_terminal_escape_input_decoder_core import ted_pkg::*;;

  localparam int IdleLimit   = 5000;
  localparam int RandomBytes = 700;

  // Mirrors the escape parser and holds the events it still owes.
  class event_scoreboard;
    state_t     pos;
    logic [7:0] code;
    logic [7:0] button;
    logic [7:0] column;
    result_t    owed[$];
    int         n_bytes;
    int         n_events;
    int         n_mouse;
    int         n_special;
    int         n_quit;
    int         errs;

    function new();
      pos       = ST_IDLE;
      code      = '0;
      button    = '0;
      column    = '0;
      n_bytes   = 0;
      n_events  = 0;
      n_mouse   = 0;
      n_special = 0;
      n_quit    = 0;
      errs      = 0;
    endfunction

    function void owe(kind_t k, logic [7:0] key, logic [7:0] btn,
                      logic [7:0] mx, logic [7:0] my);
      result_t r;
      r.kind = k;
      r.key  = key;
      r.btn  = btn;
      r.mx   = mx;
      r.my   = my;
      r.last = 1'b0;
      owed.push_back(r);
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == CH_QUIT) begin
        owe(KIND_QUIT, 8'd0, 8'd0, 8'd0, 8'd0);
      end else if (b == CH_ESC) begin
        pos = ST_ESC;
      end else begin
        owe(KIND_PLAIN, b, 8'd0, 8'd0, 8'd0);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      state_t     cur;
      int         base;
      logic [7:0] t;
      result_t    r;
      cur  = pos;
      base = owed.size();
      pos  = ST_IDLE;
      n_bytes++;
      case (cur)
        ST_ESC: begin
          if (b == CH_SS3) begin
            pos = ST_SS3;
          end else if (b == CH_CSI) begin
            pos = ST_CSI;
          end else begin
            owe(KIND_PLAIN, CH_ESC, 8'd0, 8'd0, 8'd0);
            plain_byte(b);
          end
        end
        ST_SS3: begin
          t = b - FKEY_OFS;
          owe(KIND_SPECIAL, t, 8'd0, 8'd0, 8'd0);
        end
        ST_CSI: begin
          if (b == CH_MOUSE) begin
            pos = ST_MBTN;
          end else if (b == CH_ONE) begin
            pos = ST_ONE;
          end else if (b == CH_TWO) begin
            pos = ST_TWO;
          end else if (b > CSI_FINAL) begin
            owe(KIND_SPECIAL, b, 8'd0, 8'd0, 8'd0);
          end else begin
            code = b;
            pos  = ST_CSI_TAIL;
          end
        end
        ST_MBTN: begin
          button = b;
          pos    = ST_MX;
        end
        ST_MX: begin
          column = b - MOUSE_OFS;
          pos    = ST_MY;
        end
        ST_MY: begin
          t = b - MOUSE_OFS;
          owe(KIND_MOUSE, 8'd0, button, column, t);
        end
        ST_ONE: begin
          if (b == CH_TILDE) begin
            owe(KIND_SPECIAL, CH_ONE, 8'd0, 8'd0, 8'd0);
          end else begin
            // F5..F8 skip the code right after '5'
            code = b - CH_ONE - ((b > FKEY_GAP) ? 8'd1 : 8'd0);
            pos  = ST_ONE_TAIL;
          end
        end
        ST_ONE_TAIL, ST_CSI_TAIL: begin
          owe(KIND_SPECIAL, code, 8'd0, 8'd0, 8'd0);
        end
        ST_TWO: begin
          if (b == CH_TILDE) begin
            owe(KIND_SPECIAL, CH_TWO, 8'd0, 8'd0, 8'd0);
          end else begin
            pos = ST_TWO_TAIL;
          end
        end
        ST_TWO_TAIL: begin
        end
        default: plain_byte(b);
      endcase
      if (owed.size() > base) begin
        r      = owed.pop_back();
        r.last = 1'b1;
        owed.push_back(r);
      end
    endfunction

    function void check_event(logic [1:0] kind, logic [7:0] key, logic [7:0] btn,
                              logic [7:0] mx, logic [7:0] my, logic last);
      result_t e;
      n_events++;
      if (owed.size() == 0) begin
        errs++;
        if (errs <= 10)
          $display("unexpected event: kind %0d key %0h btn %0h x %0h y %0h last %0b",
                   kind, key, btn, mx, my, last);
        return;
      end
      e = owed.pop_front();
      case (e.kind)
        KIND_MOUSE:   n_mouse++;
        KIND_SPECIAL: n_special++;
        KIND_QUIT:    n_quit++;
        default: ;
      endcase
      if (kind !== e.kind || key !== e.key || btn !== e.btn || mx !== e.mx ||
          my !== e.my || last !== e.last) begin
        errs++;
        if (errs <= 10) begin
          $display("event %0d mismatch: expected kind %0d key %0h btn %0h x %0h y %0h last %0b",
                   n_events, e.kind, e.key, e.btn, e.mx, e.my, e.last);
          $display("                    got      kind %0d key %0h btn %0h x %0h y %0h last %0b",
                   kind, key, btn, mx, my, last);
        end
      end
    endfunction

    function void close_out();
      if (owed.size() != 0) begin
        errs += owed.size();
        $display("%0d events never arrived", owed.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_key_code;
  logic [7:0]  out_mouse_button;
  logic [7:0]  out_mouse_x;
  logic [7:0]  out_mouse_y;
  logic        out_last;

  logic [31:0] cyc = '0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  logic        calm;
  logic [7:0]  stream[$];
  event_scoreboard sb;

  terminal_escape_input_decoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_key_code    (out_key_code),
    .out_mouse_button(out_mouse_button),
    .out_mouse_x     (out_mouse_x),
    .out_mouse_y     (out_mouse_y),
    .out_last        (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // one stretch in four runs with no gaps on either side
  assign calm = (cyc[9:8] == 2'b11);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly uniform, sometimes one of the bytes the parser cares about
  function automatic logic [7:0] any_byte();
    logic [7:0] hot[8];
    hot = '{CH_QUIT, CH_ESC, CH_TILDE, CH_ONE, CH_TWO, CH_MOUSE, CH_SS3, CH_CSI};
    if ($urandom_range(0, 99) < 15) return hot[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_sequence();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1: stream.push_back(any_byte());
      2: stream.push_back(CH_QUIT);
      3: stream = {stream, CH_ESC, CH_SS3, any_byte()};
      4, 5: stream = {stream, CH_ESC, CH_CSI, CH_MOUSE, any_byte(), any_byte(), any_byte()};
      6: begin
        stream = {stream, CH_ESC, CH_CSI, CH_ONE};
        if ($urandom_range(0, 2) == 0) stream.push_back(CH_TILDE);
        else if ($urandom_range(0, 1) == 0)
          stream = {stream, 8'($urandom_range(48, 57)), any_byte()};
        else
          stream = {stream, any_byte(), any_byte()};
      end
      7: begin
        stream = {stream, CH_ESC, CH_CSI, CH_TWO};
        if ($urandom_range(0, 2) == 0) stream.push_back(CH_TILDE);
        else stream = {stream, any_byte(), any_byte()};
      end
      8: begin
        if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(65, 255));
        else c = 8'($urandom_range(0, 64));
        stream = {stream, CH_ESC, CH_CSI, c};
        if (c <= CSI_FINAL) stream.push_back(any_byte());
      end
      9: stream = {stream, CH_ESC, any_byte()};
      10: begin
        // cut-off sequence, the next one starts inside it
        stream.push_back(CH_ESC);
        if ($urandom_range(0, 1) == 0) stream.push_back(CH_CSI);
      end
      default: stream = {stream, CH_ESC, CH_ESC};
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_stream();
    while (stream.size() != 0) send_byte(stream.pop_front());
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready)
        sb.check_event(out_event_kind, out_key_code, out_mouse_button, out_mouse_x,
                       out_mouse_y, out_last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, quit, ESC before quit, SS3, mouse, ESC [ 1 ~, ESC [ 2 d t,
    // ESC ESC, final CSI letter, CSI with a tail, F5..F8 form
    stream = '{8'h00, 8'hFF, CH_QUIT, CH_ESC, CH_QUIT,
               CH_ESC, CH_SS3, FKEY_OFS,
               CH_ESC, CH_CSI, CH_MOUSE, 8'hFF, 8'h00, MOUSE_OFS,
               CH_ESC, CH_CSI, CH_ONE, CH_TILDE,
               CH_ESC, CH_CSI, CH_TWO, 8'h41, CH_ESC,
               CH_ESC, CH_ESC, CH_CSI, 8'h41,
               CH_ESC, CH_CSI, CSI_FINAL, CH_QUIT,
               CH_ESC, CH_CSI, CH_ONE, 8'h37, 8'h7E};
    send_stream();

    while (sb.n_bytes < RandomBytes + 36) begin
      build_sequence();
      send_stream();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.close_out();

    $display("run covered %0d input bytes and %0d events", sb.n_bytes, sb.n_events);
    $display("  of them %0d special keys, %0d mouse reports, %0d quits; %0d errors",
             sb.n_special, sb.n_mouse, sb.n_quit, sb.errs);
    if (sb.errs == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== terminal_escape_input_decoder_core.f =====
design/ted_pkg.sv
design/ted_decode.sv
design/terminal_escape_input_decoder_core.sv
tb/tb_terminal_escape_input_decoder_core.sv
